// File: src/stma_pkg.sv
// ----------------------------------------------------------------------------
// stma_pkg: shared types and constants for the sparse triplet matrix adder
// Item kinds, output select codes and the command/status bundles that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package stma_pkg;

   localparam int DEF_MAX_A_ENTRIES = 16;
   localparam int DEF_MAX_B_ENTRIES = 16;

   localparam int IDX_W   = 8;
   localparam int VAL_W   = 16;
   localparam int SUM_W   = VAL_W + 1;
   localparam int ENTRY_W = 2 * IDX_W + VAL_W;

   // input item kinds
   localparam logic [1:0] KIND_LOAD_A = 2'd0;
   localparam logic [1:0] KIND_LOAD_B = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   // what the output register takes on an emit
   localparam logic [1:0] EMIT_A      = 2'd0;
   localparam logic [1:0] EMIT_SUM    = 2'd1;
   localparam logic [1:0] EMIT_B      = 2'd2;
   localparam logic [1:0] EMIT_HEADER = 2'd3;

   typedef struct packed {
      logic       load;      // store req fields into A or B
      logic       capture;   // finish accepted: latch dims, clear emit count
      logic       clr_i;
      logic       inc_i;
      logic       clr_k;
      logic       inc_k;
      logic       emit;
      logic [1:0] emit_sel;
      logic       done;      // empty both stores, clear drop flag
   } cmd_type;

   typedef struct packed {
      logic a_empty;
      logic b_empty;
      logic i_end;       // A index reached A count
      logic i_last;      // A index on last A entry
      logic k_end;       // B index reached B count
      logic k_last;      // B index on last B entry
      logic pos_match;   // fetched A and B entries share a position
      logic sum_zero;    // their values sum to zero
   } status_type;

endpackage

// File: src/stma_ctrl.sv
// ----------------------------------------------------------------------------
// stma_ctrl: sequencer for the sparse triplet matrix adder
// Takes load and finish beats, then walks both stores pairwise for the
// finish run and closes it with the header.
// ----------------------------------------------------------------------------
module stma_ctrl
   import stma_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_kind,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_A_WAIT = 3'd1;
   localparam logic [2:0] ST_A_CMP  = 3'd2;
   localparam logic [2:0] ST_B_WAIT = 3'd3;
   localparam logic [2:0] ST_B_CMP  = 3'd4;
   localparam logic [2:0] ST_HDR    = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_kind inside {KIND_LOAD_A, KIND_LOAD_B}) begin
                  cmd.load = 1'b1;
               end else if (req_kind == KIND_FINISH) begin
                  cmd.capture = 1'b1;
                  cmd.clr_i   = 1'b1;
                  cmd.clr_k   = 1'b1;
                  if (!status.a_empty) begin
                     state_in = ST_A_WAIT;
                  end else if (!status.b_empty) begin
                     state_in = ST_B_WAIT;
                  end else begin
                     state_in = ST_HDR;
                  end
               end
            end
         end
         ST_A_WAIT: begin
            state_in = ST_A_CMP;
         end
         ST_A_CMP: begin
            if (status.k_end || status.pos_match) begin
               // this A entry is settled: emit it alone or as a nonzero sum
               if (status.k_end) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = EMIT_A;
               end else if (!status.sum_zero) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = EMIT_SUM;
               end
               cmd.clr_k = 1'b1;
               if (status.i_last) begin
                  cmd.clr_i = 1'b1;
                  state_in  = status.b_empty ? ST_HDR : ST_B_WAIT;
               end else begin
                  cmd.inc_i = 1'b1;
                  state_in  = ST_A_WAIT;
               end
            end else begin
               cmd.inc_k = 1'b1;
               state_in  = ST_A_WAIT;
            end
         end
         ST_B_WAIT: begin
            state_in = ST_B_CMP;
         end
         ST_B_CMP: begin
            if (status.i_end || status.pos_match) begin
               if (status.i_end) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = EMIT_B;
               end
               cmd.clr_i = 1'b1;
               if (status.k_last) begin
                  state_in = ST_HDR;
               end else begin
                  cmd.inc_k = 1'b1;
                  state_in  = ST_B_WAIT;
               end
            end else begin
               cmd.inc_i = 1'b1;
               state_in  = ST_B_WAIT;
            end
         end
         ST_HDR: begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = EMIT_HEADER;
            cmd.done     = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: src/stma_dpath.sv
// ----------------------------------------------------------------------------
// stma_dpath: stores, walk indexes and result register
// Two entry memories with registered reads, their fill counts, the position
// compare and value adder, and the one-cycle result strobe.
// ----------------------------------------------------------------------------
module stma_dpath
   import stma_pkg::*;
#(
   parameter int MAX_A_ENTRIES = DEF_MAX_A_ENTRIES,
   parameter int MAX_B_ENTRIES = DEF_MAX_B_ENTRIES,
   parameter int CNT_W         = $clog2(MAX_A_ENTRIES + MAX_B_ENTRIES + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic [1:0]              req_kind,
   input  logic [IDX_W-1:0]        req_row,
   input  logic [IDX_W-1:0]        req_col,
   input  logic signed [VAL_W-1:0] req_value,
   output logic                    rsp_valid,
   output logic [IDX_W-1:0]        rsp_out_row,
   output logic [IDX_W-1:0]        rsp_out_col,
   output logic signed [SUM_W-1:0] rsp_out_value,
   output logic [CNT_W-1:0]        rsp_entry_count,
   output logic                    rsp_is_header,
   output logic                    rsp_dropped,
   output logic                    rsp_last
);

   localparam int ACW = $clog2(MAX_A_ENTRIES + 1);
   localparam int BCW = $clog2(MAX_B_ENTRIES + 1);
   localparam int AAW = (MAX_A_ENTRIES > 1) ? $clog2(MAX_A_ENTRIES) : 1;
   localparam int BAW = (MAX_B_ENTRIES > 1) ? $clog2(MAX_B_ENTRIES) : 1;

   logic [ENTRY_W-1:0] a_mem_ff [MAX_A_ENTRIES];
   logic [ENTRY_W-1:0] b_mem_ff [MAX_B_ENTRIES];
   logic [ENTRY_W-1:0] a_q_ff;
   logic [ENTRY_W-1:0] b_q_ff;
   logic [ENTRY_W-1:0] new_entry;

   logic [ACW-1:0]   a_cnt_ff;
   logic [BCW-1:0]   b_cnt_ff;
   logic             ovf_ff;
   logic [ACW-1:0]   i_ff;
   logic [BCW-1:0]   k_ff;
   logic [IDX_W-1:0] dim_row_ff;
   logic [IDX_W-1:0] dim_col_ff;
   logic [CNT_W-1:0] n_ff;

   logic                    a_full;
   logic                    b_full;
   logic signed [SUM_W-1:0] a_ext;
   logic signed [SUM_W-1:0] b_ext;
   logic signed [SUM_W-1:0] sum;

   logic                    rsp_valid_ff;
   logic [IDX_W-1:0]        rsp_row_ff;
   logic [IDX_W-1:0]        rsp_col_ff;
   logic signed [SUM_W-1:0] rsp_value_ff;
   logic [CNT_W-1:0]        rsp_count_ff;
   logic                    rsp_hdr_ff;
   logic                    rsp_drop_ff;

   assign new_entry = {req_row, req_col, req_value};
   assign a_full    = (a_cnt_ff == ACW'(MAX_A_ENTRIES));
   assign b_full    = (b_cnt_ff == BCW'(MAX_B_ENTRIES));

   // memory writes
   always_ff @(posedge clock) begin
      if (cmd.load && req_kind == KIND_LOAD_A && !a_full) begin
         a_mem_ff[a_cnt_ff[AAW-1:0]] <= new_entry;
      end
      if (cmd.load && req_kind == KIND_LOAD_B && !b_full) begin
         b_mem_ff[b_cnt_ff[BAW-1:0]] <= new_entry;
      end
   end

   // registered reads at the walk indexes
   always_ff @(posedge clock) begin
      a_q_ff <= a_mem_ff[i_ff[AAW-1:0]];
      b_q_ff <= b_mem_ff[k_ff[BAW-1:0]];
   end

   // fill counts and drop flag
   always_ff @(posedge clock) begin
      if (reset || cmd.done) begin
         a_cnt_ff <= '0;
         b_cnt_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.load) begin
         if (req_kind == KIND_LOAD_A) begin
            if (a_full) begin
               ovf_ff <= 1'b1;
            end else begin
               a_cnt_ff <= a_cnt_ff + ACW'(1);
            end
         end else begin
            if (b_full) begin
               ovf_ff <= 1'b1;
            end else begin
               b_cnt_ff <= b_cnt_ff + BCW'(1);
            end
         end
      end
   end

   // walk indexes, header dims and emit count
   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff <= '0;
         k_ff <= '0;
         n_ff <= '0;
      end else begin
         if (cmd.clr_i) begin
            i_ff <= '0;
         end else if (cmd.inc_i) begin
            i_ff <= i_ff + ACW'(1);
         end
         if (cmd.clr_k) begin
            k_ff <= '0;
         end else if (cmd.inc_k) begin
            k_ff <= k_ff + BCW'(1);
         end
         if (cmd.capture) begin
            n_ff <= '0;
         end else if (cmd.emit && cmd.emit_sel != EMIT_HEADER) begin
            n_ff <= n_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         dim_row_ff <= req_row;
         dim_col_ff <= req_col;
      end
   end

   assign a_ext = SUM_W'(signed'(a_q_ff[VAL_W-1:0]));
   assign b_ext = SUM_W'(signed'(b_q_ff[VAL_W-1:0]));
   assign sum   = a_ext + b_ext;

   always_comb begin
      status.a_empty   = (a_cnt_ff == '0);
      status.b_empty   = (b_cnt_ff == '0);
      status.i_end     = (i_ff == a_cnt_ff);
      status.i_last    = (i_ff == a_cnt_ff - ACW'(1));
      status.k_end     = (k_ff == b_cnt_ff);
      status.k_last    = (k_ff == b_cnt_ff - BCW'(1));
      status.pos_match = (a_q_ff[ENTRY_W-1:VAL_W] == b_q_ff[ENTRY_W-1:VAL_W]);
      status.sum_zero  = (sum == '0);
   end

   // result register, strobed for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_count_ff <= '0;
         rsp_hdr_ff   <= 1'b0;
         rsp_drop_ff  <= 1'b0;
         case (cmd.emit_sel)
            EMIT_A: begin
               rsp_row_ff   <= a_q_ff[ENTRY_W-1 -: IDX_W];
               rsp_col_ff   <= a_q_ff[VAL_W +: IDX_W];
               rsp_value_ff <= a_ext;
            end
            EMIT_SUM: begin
               rsp_row_ff   <= a_q_ff[ENTRY_W-1 -: IDX_W];
               rsp_col_ff   <= a_q_ff[VAL_W +: IDX_W];
               rsp_value_ff <= sum;
            end
            EMIT_B: begin
               rsp_row_ff   <= b_q_ff[ENTRY_W-1 -: IDX_W];
               rsp_col_ff   <= b_q_ff[VAL_W +: IDX_W];
               rsp_value_ff <= b_ext;
            end
            default: begin
               rsp_row_ff   <= dim_row_ff;
               rsp_col_ff   <= dim_col_ff;
               rsp_value_ff <= '0;
               rsp_count_ff <= n_ff;
               rsp_hdr_ff   <= 1'b1;
               rsp_drop_ff  <= ovf_ff;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_out_col     = rsp_col_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_header   = rsp_hdr_ff;
   assign rsp_dropped     = rsp_drop_ff;
   assign rsp_last        = rsp_hdr_ff;

endmodule

// File: src/sparse_triplet_matrix_add_core.sv
// ----------------------------------------------------------------------------
// sparse_triplet_matrix_add_core: sparse matrix sum in triplet form
// Load beats fill the A and B stores; a finish beat emits C = A + B as
// triplets and ends with a header beat that carries dims and entry count.
// ----------------------------------------------------------------------------
// Loads: one beat per cycle while idle, busy stays low, nothing is returned.
// Finish: busy through the A pass, the B pass and the header; the inner scan
//   stops at the first position match, and each compare waits for the
//   registered read of each store in a wait state. The header strobes in
//   the first cycle busy is low again; entry beats come earlier, one at a
//   time.
// Reset (synchronous, active high) empties both stores and clears the drop
//   flag; results are never stalled by the receiver.
module sparse_triplet_matrix_add_core
   import stma_pkg::*;
#(
   parameter int MAX_A_ENTRIES = DEF_MAX_A_ENTRIES,
   parameter int MAX_B_ENTRIES = DEF_MAX_B_ENTRIES,
   parameter int CNT_W         = $clog2(MAX_A_ENTRIES + MAX_B_ENTRIES + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   // command beat
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_kind,
   input  logic [IDX_W-1:0]        req_row,
   input  logic [IDX_W-1:0]        req_col,
   input  logic signed [VAL_W-1:0] req_value,
   // result beat
   output logic                    rsp_valid,
   output logic [IDX_W-1:0]        rsp_out_row,
   output logic [IDX_W-1:0]        rsp_out_col,
   output logic signed [SUM_W-1:0] rsp_out_value,
   output logic [CNT_W-1:0]        rsp_entry_count,
   output logic                    rsp_is_header,
   output logic                    rsp_dropped,
   output logic                    rsp_last
);

   cmd_type    cmd;
   status_type status;

   // Controller: accepts beats while idle, runs the A pass (each A entry
   // scans B for its first match), then the B pass (each B entry scans A
   // for any match), then the header, which also empties the stores.
   stma_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // Datapath: stores, counts, compare/add and the output register.
   stma_dpath #(
      .MAX_A_ENTRIES (MAX_A_ENTRIES),
      .MAX_B_ENTRIES (MAX_B_ENTRIES),
      .CNT_W         (CNT_W)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_kind        (req_kind),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_value   (rsp_out_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_header   (rsp_is_header),
      .rsp_dropped     (rsp_dropped),
      .rsp_last        (rsp_last)
   );

endmodule

// File: src/stma_checker.sv
// ----------------------------------------------------------------------------
// stma_checker: port-level checks for the sparse triplet matrix adder
// Watches the command and result beats and the busy flag over time.
// ----------------------------------------------------------------------------
module stma_checker
   import stma_pkg::*;
#(
   parameter int CNT_W = 6
) (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic [1:0]       req_kind,
   input logic             rsp_valid,
   input logic [CNT_W-1:0] rsp_entry_count,
   input logic             rsp_is_header,
   input logic             rsp_last
);

   // a finish beat always starts a run
   a_finish_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_kind == KIND_FINISH |=> busy)
      else $error("finish beat did not raise busy");

   // entry beats only come out during a run
   a_entry_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_header |-> busy)
      else $error("entry beat outside a finish run");

   // the header closes the run
   a_header_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_header |-> rsp_last && !busy)
      else $error("header beat not last or run still busy");

   // count is only carried by the header
   a_count_hdr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_header |-> rsp_entry_count == '0 && !rsp_last)
      else $error("entry beat carries count or last");

endmodule

bind sparse_triplet_matrix_add_core stma_checker #(
   .CNT_W (CNT_W)
) u_stma_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_kind        (req_kind),
   .rsp_valid       (rsp_valid),
   .rsp_entry_count (rsp_entry_count),
   .rsp_is_header   (rsp_is_header),
   .rsp_last        (rsp_last)
);
